// ----- rtl/rle_seg_pkg.sv -----
// Shared constants and types of the RLE transmit segmenter.
package rle_seg_pkg;

   localparam int FRAG_ID_COUNT = 8;
   localparam int FRAG_ID_W     = $clog2(FRAG_ID_COUNT);

   localparam int OPP_W  = 16;
   localparam int LEN_W  = 13;
   localparam int HDR_W  = 4;
   localparam int HSUM_W = 5;
   localparam int FID_W  = 3;
   localparam int CODE_W = 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PPDU   = 3'd0,
      CSR_HDR_FULL   = 3'd1,
      CSR_HDR_START  = 3'd2,
      CSR_HDR_CONT   = 3'd3,
      CSR_HDR_END    = 3'd4,
      CSR_HDR_EXTRA  = 3'd5
   } csr_idx_type;

   typedef enum logic [CODE_W-1:0] {
      RES_SENT      = 2'd0,
      RES_EMPTY     = 2'd1,
      RES_TOO_SMALL = 2'd2
   } res_code_type;

   typedef struct packed {
      logic [0:0]       remain_is_end;
      logic [LEN_W-1:0] remain_length;
      logic [HSUM_W-1:0] header_bytes;
      logic [LEN_W-1:0] total_length;
      logic [LEN_W-1:0] payload_length;
      logic [FID_W-1:0] frag_id;
      logic             end_flag;
      logic             start_flag;
   } rsp_fields_type;

endpackage

// ----- rtl/rle_tx_segmenter.sv -----
// Top level of the RLE transmit segmenter: one PDU decision per opportunity.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: opportunity, head length; tuser: head_is_end
//  rsp      out        rsp_tvalid/rsp_tready  tdata: header fields and lengths; tuser: result code
//  csr      in         csr_valid/csr_ready    csr_index, csr_wdata (always ready)
//
// One item per cycle sustained while rsp_tready holds; each item passes the input register, then the result register.
// The decision logic between the two registers also advances the fragment id counter.
// Synchronous reset restores register defaults, clears the counter and empties both stages.
// A stalled rsp side holds the result; the input stage keeps accepting until both stages fill.
module rle_tx_segmenter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] opportunity_bytes, [28:16] head_length, [31:29] zero
   input  logic [rle_seg_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] head_is_end
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] start_flag, [1] end_flag, [4:2] frag_id, [17:5] payload_length,
   // [30:18] total_length, [35:31] header_bytes, [48:36] remain_length,
   // [49] remain_is_end, [55:50] zero
   output logic [rle_seg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] result_code
   output logic [rle_seg_pkg::CODE_W-1:0]       rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rle_seg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rle_seg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [rle_seg_pkg::LEN_W-1:0]     max_ppdu_ff;
   logic [rle_seg_pkg::HDR_W-1:0]     hdr_full_ff, hdr_start_ff, hdr_cont_ff;
   logic [rle_seg_pkg::HDR_W-1:0]     hdr_end_ff, hdr_extra_ff;
   logic [rle_seg_pkg::FRAG_ID_W-1:0] frag_cnt_ff, frag_cnt_in;

   logic                              in_valid_ff;
   logic [rle_seg_pkg::OPP_W-1:0]     opp_ff;
   logic [rle_seg_pkg::LEN_W-1:0]     len_ff;
   logic                              is_end_ff;

   logic                              out_valid_ff;
   rle_seg_pkg::rsp_fields_type       rsp_ff, rsp_in;
   rle_seg_pkg::res_code_type         code_ff, code_in;

   logic                              out_free;
   logic                              advance;
   logic                              csr_we;

   logic [rle_seg_pkg::LEN_W-1:0]     cap;
   logic [rle_seg_pkg::HSUM_W-1:0]    fit_hdr, frag_hdr;
   logic [rle_seg_pkg::LEN_W-1:0]     fit_room, seg, seg_raw;
   logic                              cap_le_fit, cap_le_frag;
   logic [rle_seg_pkg::FRAG_ID_W:0]   cnt_inc;
   logic [rle_seg_pkg::FRAG_ID_W-1:0] cnt_next;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;
   assign csr_we     = csr_valid && csr_ready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = code_ff;
   assign rsp_tdata  = {{(rle_seg_pkg::RSP_DATA_W - $bits(rsp_ff)){1'b0}}, rsp_ff};

   always_comb begin
      cap = (opp_ff < {{(rle_seg_pkg::OPP_W - rle_seg_pkg::LEN_W){1'b0}}, max_ppdu_ff})
            ? opp_ff[rle_seg_pkg::LEN_W-1:0] : max_ppdu_ff;
      fit_hdr  = {1'b0, (is_end_ff ? hdr_end_ff : hdr_full_ff)} + {1'b0, hdr_extra_ff};
      frag_hdr = {1'b0, (is_end_ff ? hdr_cont_ff : hdr_start_ff)} + {1'b0, hdr_extra_ff};
      cap_le_fit  = cap <= {{(rle_seg_pkg::LEN_W - rle_seg_pkg::HSUM_W){1'b0}}, fit_hdr};
      cap_le_frag = cap <= {{(rle_seg_pkg::LEN_W - rle_seg_pkg::HSUM_W){1'b0}}, frag_hdr};
      fit_room = cap - {{(rle_seg_pkg::LEN_W - rle_seg_pkg::HSUM_W){1'b0}}, fit_hdr};
      seg_raw  = cap - {{(rle_seg_pkg::LEN_W - rle_seg_pkg::HSUM_W){1'b0}}, frag_hdr};
      seg      = (seg_raw >= len_ff) ? len_ff - 1'b1 : seg_raw;

      cnt_inc  = {1'b0, frag_cnt_ff} + 1'b1;
      cnt_next = (cnt_inc >= (rle_seg_pkg::FRAG_ID_W + 1)'(rle_seg_pkg::FRAG_ID_COUNT))
                 ? '0 : cnt_inc[rle_seg_pkg::FRAG_ID_W-1:0];

      frag_cnt_in = frag_cnt_ff;
      code_in     = rle_seg_pkg::RES_SENT;
      rsp_in      = '0;

      if (len_ff == '0) begin
         code_in = rle_seg_pkg::RES_EMPTY;
      end else if (cap_le_fit) begin
         code_in              = rle_seg_pkg::RES_TOO_SMALL;
         rsp_in.remain_length = len_ff;
         rsp_in.remain_is_end = is_end_ff;
      end else if (len_ff <= fit_room) begin
         rsp_in.payload_length = len_ff;
         rsp_in.end_flag       = 1'b1;
         rsp_in.header_bytes   = fit_hdr;
         if (is_end_ff) begin
            rsp_in.frag_id = rle_seg_pkg::FID_W'(frag_cnt_ff);
         end else begin
            rsp_in.start_flag = 1'b1;
         end
      end else if (cap_le_frag) begin
         code_in              = rle_seg_pkg::RES_TOO_SMALL;
         rsp_in.remain_length = len_ff;
         rsp_in.remain_is_end = is_end_ff;
      end else begin
         rsp_in.header_bytes   = frag_hdr;
         rsp_in.payload_length = seg;
         rsp_in.remain_length  = len_ff - seg;
         rsp_in.remain_is_end  = 1'b1;
         if (is_end_ff) begin
            rsp_in.frag_id = rle_seg_pkg::FID_W'(frag_cnt_ff);
         end else begin
            frag_cnt_in         = cnt_next;
            rsp_in.start_flag   = 1'b1;
            rsp_in.total_length = len_ff;
            rsp_in.frag_id      = rle_seg_pkg::FID_W'(cnt_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ppdu_ff  <= rle_seg_pkg::LEN_W'(2048);
         hdr_full_ff  <= rle_seg_pkg::HDR_W'(2);
         hdr_start_ff <= rle_seg_pkg::HDR_W'(4);
         hdr_cont_ff  <= rle_seg_pkg::HDR_W'(2);
         hdr_end_ff   <= rle_seg_pkg::HDR_W'(2);
         hdr_extra_ff <= '0;
         frag_cnt_ff  <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               rle_seg_pkg::CSR_MAX_PPDU:  max_ppdu_ff  <= csr_wdata;
               rle_seg_pkg::CSR_HDR_FULL:  hdr_full_ff  <= csr_wdata[rle_seg_pkg::HDR_W-1:0];
               rle_seg_pkg::CSR_HDR_START: hdr_start_ff <= csr_wdata[rle_seg_pkg::HDR_W-1:0];
               rle_seg_pkg::CSR_HDR_CONT:  hdr_cont_ff  <= csr_wdata[rle_seg_pkg::HDR_W-1:0];
               rle_seg_pkg::CSR_HDR_END:   hdr_end_ff   <= csr_wdata[rle_seg_pkg::HDR_W-1:0];
               rle_seg_pkg::CSR_HDR_EXTRA: hdr_extra_ff <= csr_wdata[rle_seg_pkg::HDR_W-1:0];
               default: ;
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            frag_cnt_ff <= frag_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         opp_ff    <= req_tdata[rle_seg_pkg::OPP_W-1:0];
         len_ff    <= req_tdata[rle_seg_pkg::OPP_W +: rle_seg_pkg::LEN_W];
         is_end_ff <= req_tuser;
      end
      if (advance) begin
         rsp_ff  <= rsp_in;
         code_ff <= code_in;
      end
   end

endmodule
